// ----- hdl/isb_pkg.sv -----
// isb_pkg: shared types, reset values, register indexes and the CRC-8 step
// for the IR shot burst sequencer. No dependencies.

package isb_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_DUR  = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// reset values
	localparam logic [15:0] GAP_TICKS_RST  = 16'd1500;
	localparam logic [7:0]  BURST_RST      = 8'd3;
	localparam logic [15:0] TICKS_DUR_RST  = 16'd2500;
	localparam logic [7:0]  SENT_IDLE      = 8'd255;

	// green command codes
	localparam logic [7:0] GREEN_CMD_OFF = 8'd0;
	localparam logic [7:0] GREEN_CMD_ON  = 8'd1;

	localparam logic [7:0] CRC_POLY = 8'h07;

	// result of one tick, handed from the tick core to the beat serializer
	typedef struct packed {
		logic       send;      // tick sends a packet
		logic [7:0] id;
		logic [7:0] dmg;
		logic [7:0] crc_id;    // CRC-8 over the id byte alone
		logic       green;
		logic [7:0] blue;
	} tick_res_t;

	// one byte through CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7])
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- hdl/ir_shot_burst_sequencer.sv -----
// ir_shot_burst_sequencer: top level of the IR shot burst sequencer.
// Depends on isb_pkg, isb_tick_core and isb_beat_ser.
//
//   channel | signals                                         | handshake
//   --------+-------------------------------------------------+------------------
//   in      | func player_id damage duration green_level      | in_valid/in_stall
//           | blue_level                                      |
//   out     | tx_valid tx_byte last green_on blue_out         | out_valid/out_stall
//   cfg     | cfg_index cfg_data                              | cfg_we, no wait
//
// One tick is taken per cycle while in_stall is low. A quiet tick occupies the output
// for one beat, a packet tick for three beats (id, damage, crc), all through the
// single result register, so a new tick waits until the previous one's last beat leaves.
// The state update for a tick happens at the edge it is taken; its result
// sits in the result register until its last beat leaves, and the next tick
// can be taken in that same cycle.
// Reset (arst_n low) loads the register defaults and clears all tick state;
// the sent count resets to 255 so no packets go out before a shoot.
// out_stall holds the current beat; the input stalls only while a result
// is still pending that will not finish this cycle.

module ir_shot_burst_sequencer import isb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [7:0]            player_id,
	input  logic [7:0]            damage,
	input  logic [7:0]            duration,
	input  logic [7:0]            green_level,
	input  logic [7:0]            blue_level,
	// result beats
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  tx_valid,
	output logic [7:0]            tx_byte,
	output logic                  last,
	output logic                  green_on,
	output logic [7:0]            blue_out
);

	tick_res_t res;    // next-state result of the tick being offered
	logic      take;   // tick accepted this cycle

	// config registers and tick state; tick state updates only when a tick is taken
	isb_tick_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.take        (take),
		.func        (func),
		.player_id   (player_id),
		.damage      (damage),
		.duration    (duration),
		.green_level (green_level),
		.blue_level  (blue_level),
		.res         (res)
	);

	// result register and beat sequencing toward the output channel
	isb_beat_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.take      (take),
		.res_in    (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_valid  (tx_valid),
		.tx_byte   (tx_byte),
		.last      (last),
		.green_on  (green_on),
		.blue_out  (blue_out)
	);

endmodule

// ----- hdl/isb_tick_core.sv -----
// isb_tick_core: configuration registers and per-tick state update
// (gap counter, burst count, laser timer, laser commands). Uses isb_pkg.

module isb_tick_core import isb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  take,
	input  logic                  func,
	input  logic [7:0]            player_id,
	input  logic [7:0]            damage,
	input  logic [7:0]            duration,
	input  logic [7:0]            green_level,
	input  logic [7:0]            blue_level,
	output tick_res_t             res
);

	logic [15:0] gap_ticks_q;
	logic [7:0]  burst_q;
	logic [15:0] ticks_dur_q;

	logic [15:0] gap_q;
	logic [7:0]  sent_q;
	logic [23:0] timer_q;
	logic [7:0]  green_cmd_q;
	logic [7:0]  blue_cmd_q;
	logic        green_q;
	logic [7:0]  id_q;
	logic [7:0]  dmg_q;
	logic [7:0]  crc_id_q;

	logic [15:0] gap_n;
	logic [7:0]  sent_a, sent_n;
	logic [23:0] timer_a, timer_n;
	logic [7:0]  gcmd_a, bcmd_a, gcmd_n, bcmd_n;
	logic        green_n;
	logic [7:0]  id_n, dmg_n, crc_id_n;
	logic        send;

	always_comb begin
		// shoot command lands first
		id_n     = func ? player_id : id_q;
		dmg_n    = func ? damage : dmg_q;
		crc_id_n = func ? crc8_byte(8'd0, player_id) : crc_id_q;
		gcmd_a   = func ? green_level : green_cmd_q;
		bcmd_a   = func ? blue_level : blue_cmd_q;
		timer_a  = func ? 24'(duration) * 24'(ticks_dur_q) : timer_q;
		sent_a   = func ? 8'd0 : sent_q;

		// packet slot
		send   = 1'b0;
		sent_n = sent_a;
		if (gap_q < gap_ticks_q) begin
			gap_n = gap_q + 16'd1;
		end else begin
			gap_n = '0;
			if (sent_a < burst_q) begin
				send   = 1'b1;
				sent_n = sent_a + 8'd1;
			end
		end

		// laser timer
		if (timer_a != '0) begin
			timer_n = timer_a - 24'd1;
			gcmd_n  = gcmd_a;
			bcmd_n  = bcmd_a;
		end else begin
			timer_n = '0;
			gcmd_n  = '0;
			bcmd_n  = '0;
		end

		if (gcmd_n == GREEN_CMD_ON)
			green_n = 1'b1;
		else if (gcmd_n == GREEN_CMD_OFF)
			green_n = 1'b0;
		else
			green_n = green_q;

		res.send   = send;
		res.id     = id_n;
		res.dmg    = dmg_n;
		res.crc_id = crc_id_n;
		res.green  = green_n;
		res.blue   = bcmd_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q <= GAP_TICKS_RST;
			burst_q     <= BURST_RST;
			ticks_dur_q <= TICKS_DUR_RST;
			gap_q       <= '0;
			sent_q      <= SENT_IDLE;
			timer_q     <= '0;
			green_cmd_q <= '0;
			blue_cmd_q  <= '0;
			green_q     <= 1'b0;
			id_q        <= '0;
			dmg_q       <= '0;
			crc_id_q    <= '0;   // CRC of a zero id byte is zero
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAP_TICKS: gap_ticks_q <= cfg_data;
					REG_BURST:     burst_q     <= cfg_data[7:0];
					REG_TICKS_DUR: ticks_dur_q <= cfg_data;
					default:       ;
				endcase
			end
			if (take) begin
				gap_q       <= gap_n;
				sent_q      <= sent_n;
				timer_q     <= timer_n;
				green_cmd_q <= gcmd_n;
				blue_cmd_q  <= bcmd_n;
				green_q     <= green_n;
				id_q        <= id_n;
				dmg_q       <= dmg_n;
				crc_id_q    <= crc_id_n;
			end
		end
	end

endmodule

// ----- hdl/isb_beat_ser.sv -----
// isb_beat_ser: result register and beat sequencer; sends one quiet beat or
// three packet beats (id, damage, crc) per tick. Uses isb_pkg.

module isb_beat_ser import isb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      take,
	input  tick_res_t res_in,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      tx_valid,
	output logic [7:0] tx_byte,
	output logic      last,
	output logic      green_on,
	output logic [7:0] blue_out
);

	typedef enum logic [1:0] {BEAT_ID, BEAT_DMG, BEAT_CRC} beat_t;

	beat_t     beat_q;
	logic      valid_s1;
	tick_res_t res_s1;
	logic      is_last;
	logic      fin;

	assign is_last  = !res_s1.send || (beat_q == BEAT_CRC);
	assign fin      = valid_s1 && !out_stall && is_last;
	assign in_stall = valid_s1 && !fin;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= BEAT_ID;
		end else if (take) begin
			valid_s1 <= 1'b1;
			beat_q   <= BEAT_ID;
		end else if (fin) begin
			valid_s1 <= 1'b0;
			beat_q   <= BEAT_ID;
		end else if (valid_s1 && !out_stall) begin
			unique case (beat_q)
				BEAT_ID:  beat_q <= BEAT_DMG;
				BEAT_DMG: beat_q <= BEAT_CRC;
				default:  beat_q <= BEAT_ID;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_s1 <= res_in;
	end

	always_comb begin
		tx_byte = '0;
		if (res_s1.send) begin
			case (beat_q)
				BEAT_ID:  tx_byte = res_s1.id;
				BEAT_DMG: tx_byte = res_s1.dmg;
				default:  tx_byte = crc8_byte(res_s1.crc_id, res_s1.dmg);
			endcase
		end
	end

	assign out_valid = valid_s1;
	assign tx_valid  = res_s1.send;
	assign last      = is_last;
	assign green_on  = res_s1.green;
	assign blue_out  = res_s1.blue;

endmodule

// ----- hdl/isb_checker.sv -----
// isb_checker: port-level assertions for ir_shot_burst_sequencer, bound to
// the top level. Uses no package.

module isb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       last,
	input logic       green_on,
	input logic [7:0] blue_out
);

	// a quiet tick is a single zero beat
	a_quiet_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last && tx_byte == 8'd0)
		else $error("quiet beat not a single zero last beat");

	// a packet beat that is not last is followed by another packet beat
	a_packet_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && tx_valid && !last |=> out_valid && tx_valid)
		else $error("packet cut short");

	// laser state is the same on every beat of one packet
	a_laser_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && tx_valid && !last |=>
		$stable(green_on) && $stable(blue_out))
		else $error("laser state changed inside a packet");

	// a stalled beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last))
		else $error("stalled beat changed");

endmodule

bind ir_shot_burst_sequencer isb_checker u_isb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tx_valid  (tx_valid),
	.tx_byte   (tx_byte),
	.last      (last),
	.green_on  (green_on),
	.blue_out  (blue_out)
);

// ----- tb/ir_shot_burst_sequencer_test.sv -----
// ir_shot_burst_sequencer_test: self-checking bench for the IR shot burst sequencer.
// Depends on isb_pkg and ir_shot_burst_sequencer; runs a directed plan, then random
// ticks under varying register settings and handshake pressure.
`timescale 1ns / 1ps

module ir_shot_burst_sequencer_test;
	import isb_pkg::*;

	// index with no register behind it; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one output beat as the block presents it
	typedef struct packed {
		logic       txv;   // tx_valid
		logic [7:0] txb;   // tx_byte
		logic       fin;   // last
		logic       grn;   // green_on
		logic [7:0] blu;   // blue_out
	} beat_t;

	// one line of the directed plan: a register write or a tick
	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic                  fn;
		logic [7:0]            id;
		logic [7:0]            dmg;
		logic [7:0]            dur;
		logic [7:0]            gl;
		logic [7:0]            bl;
		logic                  typed;  // want holds a hand-written single beat
		beat_t                 want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic [7:0]            player_id;
	logic [7:0]            damage;
	logic [7:0]            duration;
	logic [7:0]            green_level;
	logic [7:0]            blue_level;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  tx_valid;
	logic [7:0]            tx_byte;
	logic                  last;
	logic                  green_on;
	logic [7:0]            blue_out;

	ir_shot_burst_sequencer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.player_id  (player_id),
		.damage     (damage),
		.duration   (duration),
		.green_level(green_level),
		.blue_level (blue_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.last       (last),
		.green_on   (green_on),
		.blue_out   (blue_out)
	);

	// beats still owed by the block, oldest first
	beat_t     pending_beats[$];
	plan_row_t plan[$];
	int        fail_count = 0;

	// handshake pressure, percent of cycles
	int idle_in_pct   = 0;
	int stall_out_pct = 0;

	// shadow of the register file
	logic [15:0] m_gap;
	logic [7:0]  m_burst;
	logic [15:0] m_tpd;

	// shadow of the tick state
	logic [15:0] m_gap_cnt;
	logic [7:0]  m_sent;
	logic [23:0] m_timer;
	logic [7:0]  m_green_cmd;
	logic [7:0]  m_blue_cmd;
	logic        m_green_pin;
	logic [7:0]  m_id;
	logic [7:0]  m_dmg;

	// beats produced by the last predicted tick
	beat_t tick_beats[3];
	int    tick_nbeats;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop: far beyond the slowest legal run (~250 ticks, 3 beats each, long stalls)
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// CRC-8, poly 0x07, MSB first, one byte per call
	function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic beat_t quiet_beat(input logic g, input logic [7:0] b);
		return {1'b0, 8'h00, 1'b1, g, b};
	endfunction

	// Advance the shadow state by one tick and fill tick_beats.
	// Order matters: shoot latch, gap slot, laser timer, green pin.
	task automatic predict_tick(input logic fn, input logic [7:0] id, input logic [7:0] dmg,
			input logic [7:0] dur, input logic [7:0] gl, input logic [7:0] bl);
		logic       fire;
		logic [7:0] crc;
		fire = 1'b0;
		if (fn) begin
			m_id        = id;
			m_dmg       = dmg;
			m_green_cmd = gl;
			m_blue_cmd  = bl;
			m_timer     = 24'(dur) * 24'(m_tpd);
			m_sent      = 8'd0;
		end
		// slot opens once the counter has reached gap_ticks
		if (m_gap_cnt < m_gap) begin
			m_gap_cnt = m_gap_cnt + 16'd1;
		end else begin
			if (m_sent < m_burst) begin
				fire   = 1'b1;
				m_sent = m_sent + 8'd1;
			end
			m_gap_cnt = 16'd0;
		end
		// empty timer drops both laser commands (also on a zero-duration shoot)
		if (m_timer != 24'd0) begin
			m_timer = m_timer - 24'd1;
		end else begin
			m_green_cmd = GREEN_CMD_OFF;
			m_blue_cmd  = 8'd0;
		end
		// any other green code keeps the pin
		if (m_green_cmd == GREEN_CMD_ON)
			m_green_pin = 1'b1;
		else if (m_green_cmd == GREEN_CMD_OFF)
			m_green_pin = 1'b0;
		if (!fire) begin
			tick_beats[0] = quiet_beat(m_green_pin, m_blue_cmd);
			tick_nbeats   = 1;
		end else begin
			crc = crc8_update(crc8_update(8'h00, m_id), m_dmg);
			tick_beats[0] = {1'b1, m_id,  1'b0, m_green_pin, m_blue_cmd};
			tick_beats[1] = {1'b1, m_dmg, 1'b0, m_green_pin, m_blue_cmd};
			tick_beats[2] = {1'b1, crc,   1'b1, m_green_pin, m_blue_cmd};
			tick_nbeats   = 3;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the tick is taken,
	// with in_valid still high so back-to-back ticks need no gap.
	task automatic send_tick(input logic fn, input logic [7:0] id, input logic [7:0] dmg,
			input logic [7:0] dur, input logic [7:0] gl, input logic [7:0] bl,
			input logic typed, input beat_t want);
		int k;
		while ($urandom_range(0, 99) < idle_in_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		func        = fn;
		player_id   = id;
		damage      = dmg;
		duration    = dur;
		green_level = gl;
		blue_level  = bl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// taken at this edge: book its beats before any of them can show up
		predict_tick(fn, id, dmg, dur, gl, bl);
		if (typed)
			pending_beats.push_back(want);
		else
			for (k = 0; k < tick_nbeats; k++) pending_beats.push_back(tick_beats[k]);
		@(negedge clk);
	endtask

	// Register write with the block drained; every tick owes at least one beat,
	// so an empty queue means nothing is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid = 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_GAP_TICKS: m_gap   = val;
			REG_BURST:     m_burst = val[7:0];
			REG_TICKS_DUR: m_tpd   = val;
			default: ;
		endcase
	endtask

	task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		plan.push_back(r);
	endtask

	task automatic row_tick(input logic fn, input logic [7:0] id, input logic [7:0] dmg,
			input logic [7:0] dur, input logic [7:0] gl, input logic [7:0] bl,
			input logic typed, input beat_t want);
		plan_row_t r;
		r       = '0;
		r.fn    = fn;
		r.id    = id;
		r.dmg   = dmg;
		r.dur   = dur;
		r.gl    = gl;
		r.bl    = bl;
		r.typed = typed;
		r.want  = want;
		plan.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	// receiver: random stall, changed on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_out_pct);
	end

	// scoreboard: every beat taken is matched against the oldest expectation
	always @(posedge clk) begin : beat_check
		beat_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t ns: unexpected beat tx_valid %b tx_byte %h last %b", $time,
					tx_valid, tx_byte, last);
				fail_count++;
			end else begin
				w = pending_beats.pop_front();
				check_field("tx_valid", {7'd0, w.txv}, {7'd0, tx_valid});
				check_field("tx_byte",  w.txb,         tx_byte);
				check_field("last",     {7'd0, w.fin}, {7'd0, last});
				check_field("green_on", {7'd0, w.grn}, {7'd0, green_on});
				check_field("blue_out", w.blu,         blue_out);
			end
		end
	end

	initial begin : stimulus
		int        mode;
		int        seg;
		int        n;
		logic      fn;
		logic [7:0] dur;
		logic [7:0] gl;
		logic [15:0] v;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_GAP_TICKS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		func        = 1'b0;
		player_id   = 8'd0;
		damage      = 8'd0;
		duration    = 8'd0;
		green_level = 8'd0;
		blue_level  = 8'd0;

		m_gap       = GAP_TICKS_RST;
		m_burst     = BURST_RST;
		m_tpd       = TICKS_DUR_RST;
		m_gap_cnt   = 16'd0;
		m_sent      = SENT_IDLE;
		m_timer     = 24'd0;
		m_green_cmd = GREEN_CMD_OFF;
		m_blue_cmd  = 8'd0;
		m_green_pin = 1'b0;
		m_id        = 8'd0;
		m_dmg       = 8'd0;

		// directed plan
		// after reset: slow gap, no burst pending, lasers dark
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, quiet_beat(1'b0, 8'h00));
		// plain tick ignores its payload
		row_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, quiet_beat(1'b0, 8'h00));
		// every tick a slot, two-packet burst, zero scale so the shoot clears at once
		row_cfg(REG_GAP_TICKS, 16'd0);
		row_cfg(REG_BURST, 16'd2);
		row_cfg(REG_TICKS_DUR, 16'd0);
		row_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, quiet_beat(1'b0, 8'h00));
		// no burst at all; long laser time so green codes act on the pin
		row_cfg(REG_TICKS_DUR, 16'hFFFF);
		row_cfg(REG_BURST, 16'd0);
		row_tick(1'b1, 8'h00, 8'h00, 8'h01, 8'h01, 8'h80, 1'b1, quiet_beat(1'b1, 8'h80));
		row_tick(1'b1, 8'h11, 8'h22, 8'hFF, 8'h55, 8'h01, 1'b1, quiet_beat(1'b1, 8'h01));
		row_tick(1'b1, 8'h33, 8'h44, 8'h02, 8'h00, 8'hFE, 1'b1, quiet_beat(1'b0, 8'hFE));
		// zero duration: commands drop on the shoot tick itself
		row_tick(1'b1, 8'h55, 8'h66, 8'h00, 8'h02, 8'h33, 1'b1, quiet_beat(1'b0, 8'h00));
		// upper data bits must be masked off: burst becomes 255
		row_cfg(REG_BURST, 16'hFFFF);
		row_cfg(REG_GAP_TICKS, 16'd1);
		row_cfg(REG_TICKS_DUR, 16'd1);
		row_tick(1'b1, 8'h5A, 8'hA5, 8'h03, 8'h01, 8'h7F, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		// write to a hole in the map, then widest gap
		row_cfg(REG_UNUSED, 16'hFFFF);
		row_cfg(REG_GAP_TICKS, 16'hFFFF);
		row_tick(1'b1, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 1'b0, '0);
		row_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		// shrinking the gap below the count opens a slot on the next tick
		row_cfg(REG_GAP_TICKS, 16'd0);
		row_tick(1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
		row_tick(1'b1, 8'h00, 8'h00, 8'h04, 8'h01, 8'h10, 1'b0, '0);

		idle_in_pct   = 35;
		stall_out_pct = 55;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_tick(plan[i].fn, plan[i].id, plan[i].dmg, plan[i].dur, plan[i].gl,
					plan[i].bl, plan[i].typed, plan[i].want);
		end

		// random part: three pressure modes, four register settings each
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin idle_in_pct = 35; stall_out_pct = 55; end
				1: begin idle_in_pct = 55; stall_out_pct = 35; end
				default: begin idle_in_pct = 0; stall_out_pct = 0; end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				// mostly short gaps so packets are frequent
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: v = 16'($urandom_range(0, 2));
					7, 8:    v = 16'($urandom_range(3, 10));
					default: v = 16'($urandom);
				endcase
				write_reg(REG_GAP_TICKS, v);
				// random junk in the upper byte checks the 8-bit mask
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6, 7: v = {8'($urandom), 8'($urandom_range(0, 5))};
					8:       v = {8'($urandom), 8'd254};
					default: v = 16'($urandom);
				endcase
				write_reg(REG_BURST, v);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: v = 16'($urandom_range(0, 8));
					7, 8:    v = 16'($urandom);
					default: v = 16'd0;
				endcase
				write_reg(REG_TICKS_DUR, v);
				for (n = 0; n < 18; n++) begin
					fn = ($urandom_range(0, 99) < 30);
					// short laser times mostly, so the timer runs out within a segment
					dur = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
					case ($urandom_range(0, 2))
						0:       gl = GREEN_CMD_OFF;
						1:       gl = GREEN_CMD_ON;
						default: gl = 8'($urandom);
					endcase
					send_tick(fn, 8'($urandom), 8'($urandom), dur, gl, 8'($urandom), 1'b0, '0);
				end
			end
		end

		// drain, then watch a while for stray beats
		in_valid = 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
